// ----- rtl/kbd_pkg.sv -----
package kbd_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_DIST  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_DUP   = 3'd1,
        ST_FULL  = 3'd2,
        ST_MISS  = 3'd3,
        ST_RANGE = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_CMP,
        S_CHECK,
        S_READ,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INSERT
    } t_state;

    typedef struct packed {
        t_cmd               command;
        logic signed [31:0] key;
        logic [63:0]        payload;
        logic [9:0]         entry_number;
    } t_kbd_in;

    typedef struct packed {
        t_status            status;
        logic [9:0]         bucket;
        logic [19:0]        slot;
        logic signed [31:0] key_out;
        logic [63:0]        payload_out;
        logic [10:0]        key_count_out;
    } t_kbd_out;

endpackage

// ----- rtl/key_bucket_distributor.sv -----
// Clear and an out-of-range read are answered from idle; a read fetches its entry
// first. Load and distribute bisect the held keys, then check the rank; an insert
// then shifts each key above that rank up one place and writes the new key.
// One transaction at a time: o_busy stays high until the result is issued.
// The result is presented for exactly one cycle on o_done; the receiver cannot stall.
// Synchronous active-low reset clears the sequencer and key count; no clearing pass is run.
module key_bucket_distributor #(
    parameter int MAX_KEYS  = 1024,
    parameter int SLOT_BITS = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  kbd_pkg::t_kbd_in  i_item,
    output logic              o_done,
    output kbd_pkg::t_kbd_out o_result
);

    localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W = $clog2(MAX_KEYS + 1);

    // Key table and per-bucket fill counters. Entries at or above the key
    // count are never used: an insert writes its own fill value, and clear
    // only has to drop the count. So neither memory needs a reset sweep.
    logic signed [31:0]   r_key_mem  [MAX_KEYS];
    logic [SLOT_BITS-1:0] r_fill_mem [MAX_KEYS];
    logic signed [31:0]   r_rd_key;
    logic [SLOT_BITS-1:0] r_rd_fill;

    logic                 we_key;
    logic                 we_fill;
    logic [IDX_W-1:0]     wr_addr;
    logic signed [31:0]   wr_key;
    logic [SLOT_BITS-1:0] wr_fill;
    logic [IDX_W-1:0]     rd_addr;

    // Sequencer state
    kbd_pkg::t_state   r_state, n_state;
    kbd_pkg::t_kbd_in  r_item,  n_item;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_lo,    n_lo;    // bisection window [lo, hi)
    logic [CNT_W-1:0]  r_hi,    n_hi;
    logic [IDX_W-1:0]  r_mid,   n_mid;
    logic [IDX_W-1:0]  r_idx,   n_idx;   // shift pointer, walks down to pos
    logic              r_done,  n_done;
    kbd_pkg::t_kbd_out r_res,   n_res;

    // Shared datapath terms
    logic                 accept;
    logic                 win_open;
    logic [CNT_W-1:0]     mid_full;
    logic [IDX_W-1:0]     pos_idx;
    logic                 held;
    logic                 full;
    logic                 entry_ok;
    logic [SLOT_BITS-1:0] fill_inc;

    assign accept   = i_start && !o_busy;
    assign win_open = r_lo < r_hi;
    assign mid_full = r_lo + ((r_hi - r_lo) >> 1);
    assign pos_idx  = r_lo[IDX_W-1:0];
    // Key is held only if the rank lands inside the table and matches.
    assign held     = (r_lo < r_count) && (r_rd_key == r_item.key);
    assign full     = r_count == CNT_W'(MAX_KEYS);
    assign entry_ok = 32'(i_item.entry_number) < 32'(r_count);
    // Fill counter saturates at all ones.
    assign fill_inc = (r_rd_fill == '1) ? r_rd_fill : r_rd_fill + 1'b1;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kbd_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (i_item.command)
                        kbd_pkg::CMD_LOAD,
                        kbd_pkg::CMD_DIST:  n_state = kbd_pkg::S_SEARCH;
                        kbd_pkg::CMD_READ:  n_state = entry_ok ? kbd_pkg::S_READ
                                                               : kbd_pkg::S_IDLE;
                        kbd_pkg::CMD_CLEAR: n_state = kbd_pkg::S_IDLE;
                    endcase
                end
            end
            kbd_pkg::S_SEARCH: begin
                n_state = win_open ? kbd_pkg::S_CMP : kbd_pkg::S_CHECK;
            end
            kbd_pkg::S_CMP: begin
                n_state = kbd_pkg::S_SEARCH;
            end
            kbd_pkg::S_CHECK: begin
                priority if (held || r_item.command != kbd_pkg::CMD_LOAD || full) begin
                    n_state = kbd_pkg::S_IDLE;
                end else if (r_count > r_lo) begin
                    n_state = kbd_pkg::S_SHIFT_RD;
                end else begin
                    n_state = kbd_pkg::S_INSERT;
                end
            end
            kbd_pkg::S_SHIFT_RD: begin
                n_state = kbd_pkg::S_SHIFT_WR;
            end
            kbd_pkg::S_SHIFT_WR: begin
                n_state = (r_idx == pos_idx) ? kbd_pkg::S_INSERT : kbd_pkg::S_SHIFT_RD;
            end
            kbd_pkg::S_READ,
            kbd_pkg::S_INSERT: begin
                n_state = kbd_pkg::S_IDLE;
            end
            default: begin
                n_state = kbd_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath, memory controls and result
    // ------------------------------------------------------------------
    always_comb begin
        n_item  = r_item;
        n_count = r_count;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_idx   = r_idx;
        n_done  = 1'b0;
        n_res   = r_res;
        we_key  = 1'b0;
        we_fill = 1'b0;
        wr_addr = r_idx + 1'b1;
        wr_key  = r_rd_key;
        wr_fill = r_rd_fill;
        rd_addr = r_idx;

        unique case (r_state)
            kbd_pkg::S_IDLE: begin
                // Read command fetches its entry straight away.
                rd_addr = IDX_W'(i_item.entry_number);
                if (accept) begin
                    n_item = i_item;
                    n_lo   = '0;
                    n_hi   = r_count;
                    if (i_item.command == kbd_pkg::CMD_CLEAR) begin
                        n_count = '0;
                        n_done  = 1'b1;
                        n_res   = '0;
                        n_res.status = kbd_pkg::ST_OK;
                    end else if (i_item.command == kbd_pkg::CMD_READ && !entry_ok) begin
                        n_done  = 1'b1;
                        n_res   = '0;
                        n_res.status        = kbd_pkg::ST_RANGE;
                        n_res.key_count_out = 11'(r_count);
                    end
                end
            end
            kbd_pkg::S_SEARCH: begin
                // Probe the midpoint, or the final rank once the window closes.
                n_mid   = mid_full[IDX_W-1:0];
                rd_addr = win_open ? mid_full[IDX_W-1:0] : pos_idx;
            end
            kbd_pkg::S_CMP: begin
                if (r_rd_key < r_item.key) begin
                    n_lo = CNT_W'(r_mid) + 1'b1;
                end else begin
                    n_hi = CNT_W'(r_mid);
                end
            end
            kbd_pkg::S_CHECK: begin
                n_idx = IDX_W'(r_count - 1'b1);
                if (held) begin
                    n_done = 1'b1;
                    n_res  = '0;
                    n_res.bucket        = 10'(r_lo);
                    n_res.slot          = 20'(r_rd_fill);
                    n_res.key_out       = r_item.key;
                    n_res.key_count_out = 11'(r_count);
                    if (r_item.command == kbd_pkg::CMD_LOAD) begin
                        n_res.status = kbd_pkg::ST_DUP;
                    end else begin
                        n_res.status      = kbd_pkg::ST_OK;
                        n_res.payload_out = r_item.payload;
                        we_fill = 1'b1;
                        wr_addr = pos_idx;
                        wr_fill = fill_inc;
                    end
                end else if (r_item.command != kbd_pkg::CMD_LOAD) begin
                    n_done = 1'b1;
                    n_res  = '0;
                    n_res.status        = kbd_pkg::ST_MISS;
                    n_res.key_count_out = 11'(r_count);
                end else if (full) begin
                    n_done = 1'b1;
                    n_res  = '0;
                    n_res.status        = kbd_pkg::ST_FULL;
                    n_res.key_count_out = 11'(r_count);
                end
            end
            kbd_pkg::S_READ: begin
                n_done = 1'b1;
                n_res  = '0;
                n_res.status        = kbd_pkg::ST_OK;
                n_res.bucket        = r_item.entry_number;
                n_res.slot          = 20'(r_rd_fill);
                n_res.key_out       = r_rd_key;
                n_res.key_count_out = 11'(r_count);
            end
            kbd_pkg::S_SHIFT_RD: begin
                rd_addr = r_idx;
            end
            kbd_pkg::S_SHIFT_WR: begin
                // Move entry idx (key and fill) up one place.
                we_key  = 1'b1;
                we_fill = 1'b1;
                wr_addr = r_idx + 1'b1;
                wr_key  = r_rd_key;
                wr_fill = r_rd_fill;
                if (r_idx != pos_idx) begin
                    n_idx = r_idx - 1'b1;
                end
            end
            kbd_pkg::S_INSERT: begin
                we_key  = 1'b1;
                we_fill = 1'b1;
                wr_addr = pos_idx;
                wr_key  = r_item.key;
                wr_fill = '0;
                n_count = r_count + 1'b1;
                n_done  = 1'b1;
                n_res   = '0;
                n_res.status        = kbd_pkg::ST_OK;
                n_res.bucket        = 10'(r_lo);
                n_res.key_out       = r_item.key;
                n_res.key_count_out = 11'(r_count + 1'b1);
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kbd_pkg::S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_idx  <= n_idx;
        r_res  <= n_res;
    end

    // Memories: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (we_key) begin
            r_key_mem[wr_addr] <= wr_key;
        end
        if (we_fill) begin
            r_fill_mem[wr_addr] <= wr_fill;
        end
        r_rd_key  <= r_key_mem[rd_addr];
        r_rd_fill <= r_fill_mem[rd_addr];
    end

    assign o_busy   = r_state != kbd_pkg::S_IDLE;
    assign o_done   = r_done;
    assign o_result = r_res;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_KEYS))
        else $error("key count above table size");

    a_cmp_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kbd_pkg::S_CMP) |-> (r_lo < r_hi && CNT_W'(r_mid) < r_hi))
        else $error("bisection probe outside window");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kbd_pkg::S_SHIFT_RD) |-> (r_idx >= pos_idx && !full))
        else $error("shift pointer below insert rank or table full");

    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_rst_n)) |-> $past(r_state != kbd_pkg::S_IDLE || i_start))
        else $error("result strobe without a transaction");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |->
            ($past(r_state) == kbd_pkg::S_INSERT ||
             ($past(accept) && $past(i_item.command) == kbd_pkg::CMD_CLEAR)))
        else $error("key count changed outside insert or clear");

endmodule

// ----- sim/key_bucket_distributor_tb.sv -----
module key_bucket_distributor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Block built with its default table depth and fill counter width.
    localparam int MAX_KEYS     = 1024;
    localparam int SLOT_BITS    = 20;
    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 6;
    // Longest correct operation is an insert at the front of a nearly full
    // table, which shifts every held key. The limit lies well above that.
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_LIMIT  = 100;
    localparam int RANDOM_ITEMS = 40;   // per idle stretch

    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    kbd_pkg::t_kbd_in  i_item  = '0;
    logic              o_busy;
    logic              o_done;
    kbd_pkg::t_kbd_out o_result;

    key_bucket_distributor #(
        .MAX_KEYS  (MAX_KEYS),
        .SLOT_BITS (SLOT_BITS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow of the block's table: sorted keys, key count, fill counters.
    // ------------------------------------------------------------------
    logic signed [31:0]   shadow_keys [MAX_KEYS];
    logic [SLOT_BITS-1:0] shadow_fill [MAX_KEYS];
    int unsigned          shadow_count = 0;

    // Replies owed by the block, oldest first.
    kbd_pkg::t_kbd_out table_replies_due [$];

    int mismatch_count = 0;
    int idle_pct       = 0;   // chance in percent that the sender idles a cycle
    int stall_cycles   = 0;

    // Applies one transaction to the shadow table and returns the reply the
    // block must give for it.
    function automatic kbd_pkg::t_kbd_out predict_table_op(input kbd_pkg::t_kbd_in item);
        kbd_pkg::t_kbd_out r;
        int unsigned       rank;
        int unsigned       i;
        bit                held;
        r = '0;
        r.status = kbd_pkg::ST_OK;
        // rank = number of held keys below the key, signed order
        rank = 0;
        while (rank < shadow_count && shadow_keys[rank] < item.key)
            rank++;
        held = (rank < shadow_count) && (shadow_keys[rank] == item.key);
        case (item.command)
            kbd_pkg::CMD_LOAD: begin
                if (held) begin
                    // duplicate wins over full
                    r.status  = kbd_pkg::ST_DUP;
                    r.bucket  = 10'(rank);
                    r.slot    = 20'(shadow_fill[rank]);
                    r.key_out = item.key;
                end else if (shadow_count >= MAX_KEYS) begin
                    r.status = kbd_pkg::ST_FULL;
                end else begin
                    // open a hole at rank; fill counters move with their keys
                    for (i = shadow_count; i > rank; i--) begin
                        shadow_keys[i] = shadow_keys[i-1];
                        shadow_fill[i] = shadow_fill[i-1];
                    end
                    shadow_keys[rank] = item.key;
                    shadow_fill[rank] = '0;
                    shadow_count++;
                    r.bucket  = 10'(rank);
                    r.key_out = item.key;
                end
            end
            kbd_pkg::CMD_DIST: begin
                if (held) begin
                    r.bucket      = 10'(rank);
                    r.slot        = 20'(shadow_fill[rank]);
                    r.key_out     = item.key;
                    r.payload_out = item.payload;
                    if (shadow_fill[rank] != '1)
                        shadow_fill[rank]++;
                end else begin
                    r.status = kbd_pkg::ST_MISS;
                end
            end
            kbd_pkg::CMD_READ: begin
                if (item.entry_number < shadow_count) begin
                    r.bucket  = item.entry_number;
                    r.slot    = 20'(shadow_fill[item.entry_number]);
                    r.key_out = shadow_keys[item.entry_number];
                end else begin
                    r.status = kbd_pkg::ST_RANGE;
                end
            end
            default: begin
                shadow_count = 0;
                for (i = 0; i < MAX_KEYS; i++)
                    shadow_fill[i] = '0;
            end
        endcase
        r.key_count_out = 11'(shadow_count);
        return r;
    endfunction

    function automatic kbd_pkg::t_kbd_in make_item(input kbd_pkg::t_cmd cmd,
                                                   input logic signed [31:0] key,
                                                   input logic [63:0] payload,
                                                   input logic [9:0] entry);
        kbd_pkg::t_kbd_in item;
        item.command      = cmd;
        item.key          = key;
        item.payload      = payload;
        item.entry_number = entry;
        return item;
    endfunction

    function automatic logic [63:0] random_payload();
        return {$urandom, $urandom};
    endfunction

    // Key near zero: keeps duplicates and neighbors of held keys common.
    function automatic logic signed [31:0] near_zero_key();
        logic signed [31:0] k;
        k = $urandom_range(255);
        return k - 32'sd128;
    endfunction

    function automatic logic signed [31:0] held_key();
        return shadow_keys[$urandom_range(shadow_count - 1)];
    endfunction

    // Mostly well-formed traffic: loads build a small table, distributes
    // mostly hit held keys, reads mostly land inside the table. The rest
    // are misses, neighbors of held keys, extremes and stray reads.
    function automatic kbd_pkg::t_kbd_in random_table_op();
        kbd_pkg::t_kbd_in item;
        int               pick;
        int               sel;
        item = make_item(kbd_pkg::CMD_READ, $urandom, random_payload(), 10'($urandom));
        pick = $urandom_range(199);
        sel  = $urandom_range(9);
        if (pick < 3) begin
            item.command = kbd_pkg::CMD_CLEAR;
        end else if (pick < 55) begin
            item.command = kbd_pkg::CMD_LOAD;
            if (sel < 2 && shadow_count > 0)
                item.key = held_key();
            else if (sel < 6)
                item.key = near_zero_key();
            else if (sel == 6)
                case ($urandom_range(3))
                    0: item.key = KEY_MIN;
                    1: item.key = KEY_MAX;
                    2: item.key = -32'sd1;
                    default: item.key = '0;
                endcase
        end else if (pick < 160) begin
            item.command = kbd_pkg::CMD_DIST;
            if (shadow_count > 0 && sel < 7)
                item.key = held_key();
            else if (shadow_count > 0 && sel < 8)
                item.key = held_key() + ($urandom_range(1) ? 32'sd1 : -32'sd1);
            else if (sel < 9)
                item.key = near_zero_key();
        end else begin
            if (shadow_count > 0 && sel < 8)
                item.entry_number = 10'($urandom_range(shadow_count - 1));
        end
        return item;
    endfunction

    // ------------------------------------------------------------------
    // Sender: idles at random, then holds start until the block takes the
    // transaction. The reply is predicted at the accepting edge.
    // ------------------------------------------------------------------
    task automatic send_item(input kbd_pkg::t_kbd_in item);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= item;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        table_replies_due.push_back(predict_table_op(item));
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Reply checker: every strobe must match the oldest owed reply.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        kbd_pkg::t_kbd_out want;
        string             diffs;
        if (i_rst_n && o_done !== 1'b0) begin
            if (o_done !== 1'b1) begin
                report_mismatch("done strobe is unknown");
            end else if (table_replies_due.size() == 0) begin
                report_mismatch($sformatf("reply with none owed: %p", o_result));
            end else begin
                want  = table_replies_due.pop_front();
                diffs = "";
                if (o_result.status !== want.status)
                    diffs = {diffs, $sformatf(" status %0d/%0d", o_result.status, want.status)};
                if (o_result.bucket !== want.bucket)
                    diffs = {diffs, $sformatf(" bucket %0d/%0d", o_result.bucket, want.bucket)};
                if (o_result.slot !== want.slot)
                    diffs = {diffs, $sformatf(" slot %0d/%0d", o_result.slot, want.slot)};
                if (o_result.key_out !== want.key_out)
                    diffs = {diffs, $sformatf(" key_out %0d/%0d",
                                              o_result.key_out, want.key_out)};
                if (o_result.payload_out !== want.payload_out)
                    diffs = {diffs, $sformatf(" payload_out %h/%h",
                                              o_result.payload_out, want.payload_out)};
                if (o_result.key_count_out !== want.key_count_out)
                    diffs = {diffs, $sformatf(" key_count_out %0d/%0d",
                                              o_result.key_count_out, want.key_count_out)};
                if (diffs != "")
                    report_mismatch({"got/want:", diffs});
            end
        end
    end

    // Watchdog: counts cycles with neither a transaction taken nor a reply.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && o_busy === 1'b0) || o_done === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("key_bucket_distributor_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty table, inserts at front, middle and end, duplicates, misses
    // below, between and above the held keys, reads in and out of range,
    // and a clear followed by fresh use.
    task automatic test_directed_ops();
        send_item(make_item(kbd_pkg::CMD_DIST,  32'sd0,  '1, 10'd0));    // miss, empty table
        send_item(make_item(kbd_pkg::CMD_READ,  32'sd0,  '0, 10'd0));    // out of range, empty
        send_item(make_item(kbd_pkg::CMD_CLEAR, KEY_MAX, '1, 10'h3FF));  // clear when empty
        send_item(make_item(kbd_pkg::CMD_LOAD,  32'sd10, '0, 10'd0));
        send_item(make_item(kbd_pkg::CMD_DIST,  -32'sd5, '1, 10'd0));    // below all held
        send_item(make_item(kbd_pkg::CMD_DIST,  32'sd20, '1, 10'd0));    // above all held
        send_item(make_item(kbd_pkg::CMD_LOAD,  KEY_MAX, '0, 10'd0));    // append
        send_item(make_item(kbd_pkg::CMD_LOAD,  KEY_MIN, '1, 10'h3FF));  // front insert
        send_item(make_item(kbd_pkg::CMD_LOAD,  32'sd0,  '0, 10'd0));    // middle insert
        send_item(make_item(kbd_pkg::CMD_LOAD,  -32'sd1, '0, 10'd0));
        send_item(make_item(kbd_pkg::CMD_DIST,  KEY_MIN, '1, 10'd0));
        send_item(make_item(kbd_pkg::CMD_DIST,  KEY_MAX, '0, 10'd0));
        send_item(make_item(kbd_pkg::CMD_DIST,  32'sd0,  64'h5555_AAAA_0F0F_F0F0, 10'd0));
        send_item(make_item(kbd_pkg::CMD_DIST,  32'sd0,  64'hAAAA_5555_F0F0_0F0F, 10'd0));
        send_item(make_item(kbd_pkg::CMD_DIST,  32'sd2,  '1, 10'd0));    // between held keys
        send_item(make_item(kbd_pkg::CMD_LOAD,  32'sd0,  '0, 10'd0));    // duplicate, fill 2
        send_item(make_item(kbd_pkg::CMD_READ,  32'sd0,  '0, 10'd0));
        send_item(make_item(kbd_pkg::CMD_READ,  32'sd0,  '0, 10'd4));    // last entry
        send_item(make_item(kbd_pkg::CMD_READ,  32'sd0,  '0, 10'd5));    // first beyond
        send_item(make_item(kbd_pkg::CMD_READ,  32'sd0,  '0, 10'h3FF));
        send_item(make_item(kbd_pkg::CMD_CLEAR, 32'sd0,  '0, 10'd0));
        send_item(make_item(kbd_pkg::CMD_READ,  32'sd0,  '0, 10'd0));
        send_item(make_item(kbd_pkg::CMD_DIST,  32'sd0,  '1, 10'd0));    // gone after clear
        send_item(make_item(kbd_pkg::CMD_LOAD,  32'sd0,  '0, 10'd0));
        send_item(make_item(kbd_pkg::CMD_DIST,  32'sd0,  '1, 10'd0));    // fill restarts at 0
    endtask

    // Fills the table to capacity (ascending loads are cheap, one front
    // insert shifts the whole table), then probes it while full.
    task automatic test_full_table();
        int i;
        send_item(make_item(kbd_pkg::CMD_CLEAR, $urandom, random_payload(), 10'($urandom)));
        for (i = 0; i < MAX_KEYS - 1; i++)
            send_item(make_item(kbd_pkg::CMD_LOAD, 32'sd3 * i - 32'sd1536, random_payload(),
                                10'($urandom)));
        send_item(make_item(kbd_pkg::CMD_LOAD, KEY_MIN, '0, 10'd0));    // last free place
        send_item(make_item(kbd_pkg::CMD_LOAD, 32'sd7, '0, 10'd0));     // table full
        send_item(make_item(kbd_pkg::CMD_LOAD, KEY_MIN, '0, 10'd0));    // duplicate while full
        send_item(make_item(kbd_pkg::CMD_LOAD, -32'sd36, '0, 10'd0));
        send_item(make_item(kbd_pkg::CMD_DIST, KEY_MAX, '1, 10'd0));    // above all held
        send_item(make_item(kbd_pkg::CMD_DIST, -32'sd36, random_payload(), 10'd0));
        send_item(make_item(kbd_pkg::CMD_READ, 32'sd0, '0, 10'(MAX_KEYS - 1)));
        send_item(make_item(kbd_pkg::CMD_READ, 32'sd0, '0, 10'd0));
        send_item(make_item(kbd_pkg::CMD_CLEAR, 32'sd0, '0, 10'd0));
    endtask

    // Counts up one bucket, then inserts a key below it so the bucket and
    // its fill move up one place together.
    task automatic test_fill_count();
        send_item(make_item(kbd_pkg::CMD_LOAD, 32'sd42, '0, 10'd0));
        repeat (12)
            send_item(make_item(kbd_pkg::CMD_DIST, 32'sd42, random_payload(), 10'($urandom)));
        send_item(make_item(kbd_pkg::CMD_LOAD, 32'sd40, '0, 10'd0));
        send_item(make_item(kbd_pkg::CMD_DIST, 32'sd42, random_payload(), 10'd0));
        send_item(make_item(kbd_pkg::CMD_DIST, 32'sd40, random_payload(), 10'd0));
        send_item(make_item(kbd_pkg::CMD_LOAD, 32'sd42, '0, 10'd0));    // duplicate
        send_item(make_item(kbd_pkg::CMD_READ, 32'sd0, '0, 10'd0));
        send_item(make_item(kbd_pkg::CMD_READ, 32'sd0, '0, 10'd1));
        send_item(make_item(kbd_pkg::CMD_READ, 32'sd0, '0, 10'd2));     // first beyond
        send_item(make_item(kbd_pkg::CMD_CLEAR, 32'sd0, '0, 10'd0));
    endtask

    // Random traffic in three stretches: light sender gaps, heavy gaps, none.
    task automatic test_random_traffic();
        int gaps [3] = '{31, 79, 0};
        int stretch;
        for (stretch = 0; stretch < 3; stretch++) begin
            idle_pct = gaps[stretch];
            repeat (RANDOM_ITEMS)
                send_item(random_table_op());
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 31;
        test_directed_ops();
        test_full_table();
        test_fill_count();
        test_random_traffic();

        // all transactions taken; let the last replies come out
        i_start <= 1'b0;
        while (table_replies_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && table_replies_due.size() == 0)
            $display("key_bucket_distributor_tb: clean");
        else
            $display("key_bucket_distributor_tb: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/kbd_pkg.sv
rtl/key_bucket_distributor.sv
sim/key_bucket_distributor_tb.sv
